// ===== design/two_sensor_tape_steering_defines.svh =====
// Assertion macros shared by the tape steering modules.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef TWO_SENSOR_TAPE_STEERING_DEFINES_SVH
`define TWO_SENSOR_TAPE_STEERING_DEFINES_SVH

// The condition c holds in the same cycle as the trigger a.
`define TST_ASSERT_IMPLY(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tape steering assertion failed");

// The condition c holds in the cycle after the trigger a.
`define TST_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tape steering assertion failed");

`endif

// ===== design/tst_pkg.sv =====
// Types and constants of the two-sensor tape steering block.
// Used by the controller, the datapath and the top level; depends on nothing.
package tst_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SPEED_BITS  = 8;
  localparam int HOLD_BITS   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int STEP_W      = $clog2(SAMPLE_BITS);

  // Action codes of an input item.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_ROTATE = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPE_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_ROT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_HOLD   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_BITS-1:0] DIFF_THR_RST = 12'd300;
  localparam logic [HOLD_BITS-1:0]   ROT_HOLD_RST = 16'd1000;

  typedef enum logic [1:0] {
    MODE_FOLLOW  = 2'd0,
    MODE_ROTATE  = 2'd1,
    MODE_STOPPED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]             action;
    logic [SAMPLE_BITS-1:0] right_sample;
    logic [SAMPLE_BITS-1:0] left_sample;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_BITS-1:0]  left_speed;
    logic [SPEED_BITS-1:0]  right_speed;
    logic                   left_reverse;
    logic                   right_reverse;
    logic                   turn_done;
    logic [1:0]             mode_now;
    logic [SAMPLE_BITS-1:0] left_average;
    logic [SAMPLE_BITS-1:0] right_average;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic mem_read;
    logic update;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/two_sensor_tape_steering.sv =====
// Top level of the two-sensor tape steering block.
// Depends on tst_pkg, tst_ctrl and tst_dp.

// Each accepted item yields exactly one result. A sample pair passes from
// acceptance to a registered result in steps: read the oldest window entry,
// update the running totals, load the mean dividers, run twelve steps of the
// bit-serial dividers that share the fill count as divisor, and decide the
// drive once the result register is free. Rotate, resume and unused actions
// skip the window. One item is in work at a time; the next is accepted in the
// cycle after the result is registered, even while that result waits to be
// taken. Configuration writes take effect at once and belong to idle periods.
module two_sensor_tape_steering #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tst_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tst_pkg::out_item_t                out_data
);
  import tst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_is_sample (in_data.action == ACT_SAMPLE),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .status       (status)
  );

  tst_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/tst_ctrl.sv =====
// Sequencing controller of the tape steering block.
// Depends on tst_pkg and on the assertion macros of the defines header.
`include "two_sensor_tape_steering_defines.svh"

module tst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_is_sample,
  output logic                 in_ready,
  output tst_pkg::dp_cmd_t     cmd,
  input  tst_pkg::dp_status_t  status
);
  import tst_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_is_sample ? ST_READ : ST_START;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result register must be empty or draining before it is loaded.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `TST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TST_ASSERT_NEXT(a_divide_ends, state_r == ST_DIVIDE && status.div_last,
                   state_r == ST_FINISH)

endmodule

// ===== design/tst_dp.sv =====
// Datapath of the tape steering block: sample windows, running totals,
// serial mean dividers, drive mode state and the result register.
// Depends on tst_pkg and on the assertion macros of the defines header.
`include "two_sensor_tape_steering_defines.svh"

module tst_dp #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tst_pkg::in_item_t                 in_data,
  input  tst_pkg::dp_cmd_t                  cmd,
  output tst_pkg::dp_status_t               status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tst_pkg::out_item_t                out_data
);
  import tst_pkg::*;

  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int TW = SAMPLE_BITS + CW;

  // One restoring division step: returns the quotient bit and the new remainder.
  function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
                                           input logic          din,
                                           input logic [CW-1:0] dsr);
    logic [CW:0] trial;
    trial = {rem, din};
    if (trial >= {1'b0, dsr}) begin
      return {1'b1, CW'(trial - {1'b0, dsr})};
    end else begin
      return {1'b0, trial[CW-1:0]};
    end
  endfunction

  logic [SAMPLE_BITS-1:0] diff_thr_r;
  logic [SAMPLE_BITS-1:0] tape_thr_r;
  logic [SPEED_BITS-1:0]  speed_low_r;
  logic [SPEED_BITS-1:0]  speed_high_r;
  logic [SPEED_BITS-1:0]  speed_rot_r;
  logic [HOLD_BITS-1:0]   rot_hold_r;

  in_item_t item_r;

  logic [2*SAMPLE_BITS-1:0] mem [0:WINDOW_DEPTH-1];
  logic [2*SAMPLE_BITS-1:0] rd_r;

  logic [SW-1:0] slot_r;
  logic [CW-1:0] fill_r;
  logic [TW-1:0] ltot_r;
  logic [TW-1:0] rtot_r;
  logic [TW-1:0] ltot_nxt;
  logic [TW-1:0] rtot_nxt;
  logic          full;

  logic [CW-1:0]          lrem_r;
  logic [CW-1:0]          rrem_r;
  logic [SAMPLE_BITS-1:0] llo_r;
  logic [SAMPLE_BITS-1:0] rlo_r;
  logic [SAMPLE_BITS-1:0] lquo_r;
  logic [SAMPLE_BITS-1:0] rquo_r;
  logic [STEP_W-1:0]      step_r;
  logic [CW:0]            lstep;
  logic [CW:0]            rstep;

  mode_t                mode_r;
  mode_t                mode_nxt;
  mode_t                mode_eff;
  logic [HOLD_BITS-1:0] hold_r;
  logic [HOLD_BITS-1:0] hold_nxt;
  logic [HOLD_BITS-1:0] hold_eff;

  logic [SAMPLE_BITS-1:0] lmean;
  logic [SAMPLE_BITS-1:0] rmean;
  logic [SPEED_BITS-1:0]  lspeed;
  logic [SPEED_BITS-1:0]  rspeed;
  logic                   lrev;
  logic                   done;

  logic      out_valid_r;
  out_item_t out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_thr_r   <= DIFF_THR_RST;
      tape_thr_r   <= '0;
      speed_low_r  <= '0;
      speed_high_r <= '0;
      speed_rot_r  <= '0;
      rot_hold_r   <= ROT_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_THR:   diff_thr_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_TAPE_THR:   tape_thr_r   <= cfg_data[SAMPLE_BITS-1:0];
        REG_SPEED_LOW:  speed_low_r  <= cfg_data[SPEED_BITS-1:0];
        REG_SPEED_HIGH: speed_high_r <= cfg_data[SPEED_BITS-1:0];
        REG_SPEED_ROT:  speed_rot_r  <= cfg_data[SPEED_BITS-1:0];
        REG_ROT_HOLD:   rot_hold_r   <= cfg_data[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
  end

  // Window memory: both channels share one word per slot.
  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_r <= mem[slot_r];
    end
    if (cmd.update) begin
      mem[slot_r] <= {item_r.left_sample, item_r.right_sample};
    end
  end

  assign full = (fill_r == CW'(WINDOW_DEPTH));

  // Once the window is full, the oldest entry leaves the total.
  always_comb begin
    if (full) begin
      ltot_nxt = ltot_r - TW'(rd_r[2*SAMPLE_BITS-1:SAMPLE_BITS])
                 + TW'(item_r.left_sample);
      rtot_nxt = rtot_r - TW'(rd_r[SAMPLE_BITS-1:0]) + TW'(item_r.right_sample);
    end else begin
      ltot_nxt = ltot_r + TW'(item_r.left_sample);
      rtot_nxt = rtot_r + TW'(item_r.right_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      ltot_r <= '0;
      rtot_r <= '0;
    end else if (cmd.update) begin
      ltot_r <= ltot_nxt;
      rtot_r <= rtot_nxt;
      slot_r <= (slot_r == SW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // The mean never exceeds the largest sample, so the upper bits of a total
  // are always below the fill count and seed the remainder directly.
  assign lstep = div_step(lrem_r, llo_r[SAMPLE_BITS-1], fill_r);
  assign rstep = div_step(rrem_r, rlo_r[SAMPLE_BITS-1], fill_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      lrem_r <= ltot_r[TW-1:SAMPLE_BITS];
      rrem_r <= rtot_r[TW-1:SAMPLE_BITS];
      llo_r  <= ltot_r[SAMPLE_BITS-1:0];
      rlo_r  <= rtot_r[SAMPLE_BITS-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      lrem_r <= lstep[CW-1:0];
      rrem_r <= rstep[CW-1:0];
      llo_r  <= {llo_r[SAMPLE_BITS-2:0], 1'b0};
      rlo_r  <= {rlo_r[SAMPLE_BITS-2:0], 1'b0};
      lquo_r <= {lquo_r[SAMPLE_BITS-2:0], lstep[CW]};
      rquo_r <= {rquo_r[SAMPLE_BITS-2:0], rstep[CW]};
      step_r <= step_r + 1'b1;
    end
  end

  assign status.div_last = (step_r == STEP_W'(SAMPLE_BITS - 1));
  assign status.out_free = !out_valid_r || out_ready;

  // Empty windows read as a mean of zero.
  assign lmean = (fill_r == '0) ? '0 : lquo_r;
  assign rmean = (fill_r == '0) ? '0 : rquo_r;

  // Mode update and drive decision for the item in hand.
  always_comb begin
    mode_eff = mode_r;
    hold_eff = hold_r;
    case (item_r.action)
      ACT_ROTATE: begin
        mode_eff = MODE_ROTATE;
        hold_eff = rot_hold_r;
      end
      ACT_RESUME: begin
        mode_eff = MODE_FOLLOW;
      end
      default: ;
    endcase

    mode_nxt = mode_eff;
    hold_nxt = hold_eff;
    lspeed   = '0;
    rspeed   = '0;
    lrev     = 1'b0;
    done     = 1'b0;
    case (mode_eff)
      MODE_FOLLOW: begin
        if ({1'b0, rmean} > ({1'b0, lmean} + {1'b0, diff_thr_r})) begin
          lspeed = speed_low_r;
          rspeed = speed_high_r;
        end else if ({1'b0, lmean} > ({1'b0, rmean} + {1'b0, diff_thr_r})) begin
          lspeed = speed_high_r;
          rspeed = speed_low_r;
        end else begin
          lspeed = speed_high_r;
          rspeed = speed_high_r;
        end
      end
      MODE_ROTATE: begin
        if (item_r.action == ACT_SAMPLE && hold_eff != '0) begin
          hold_nxt = hold_eff - 1'b1;
        end else if (item_r.action == ACT_SAMPLE && rmean > tape_thr_r &&
                     lmean > tape_thr_r) begin
          mode_nxt = MODE_STOPPED;
          done     = 1'b1;
        end
        if (!done) begin
          lspeed = speed_rot_r;
          rspeed = speed_rot_r;
          lrev   = 1'b1;
        end
      end
      MODE_STOPPED: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FOLLOW;
      hold_r <= '0;
    end else if (cmd.finish) begin
      mode_r <= mode_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.left_speed    <= lspeed;
      out_r.right_speed   <= rspeed;
      out_r.left_reverse  <= lrev;
      out_r.right_reverse <= 1'b0;
      out_r.turn_done     <= done;
      out_r.mode_now      <= mode_nxt;
      out_r.left_average  <= lmean;
      out_r.right_average <= rmean;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TST_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_r <= CW'(WINDOW_DEPTH))
  `TST_ASSERT_IMPLY(a_done_stops, out_valid_r && out_r.turn_done,
                    out_r.mode_now == MODE_STOPPED && out_r.left_speed == '0 &&
                    out_r.right_speed == '0 && !out_r.left_reverse)
  `TST_ASSERT_NEXT(a_finish_loads, cmd.finish, out_valid_r)

endmodule

// ===== test/tb_two_sensor_tape_steering.sv =====
// Self-checking testbench for the two-sensor tape steering block.
// Needs tst_pkg and the two_sensor_tape_steering RTL; a scoreboard class predicts
// every result from accepted items and checks what comes out.
`timescale 1ns / 1ps

module tb_two_sensor_tape_steering;
  import tst_pkg::*;

  localparam int WIN_DEPTH = 16;
  localparam int N_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 100;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  class steer_scoreboard;
    logic [SAMPLE_BITS-1:0] diff_thr, tape_thr;
    logic [SPEED_BITS-1:0] spd_low, spd_high, spd_rot;
    logic [HOLD_BITS-1:0] rot_hold;
    logic [SAMPLE_BITS-1:0] left_win[WIN_DEPTH];
    logic [SAMPLE_BITS-1:0] right_win[WIN_DEPTH];
    logic [3:0] slot;
    logic [4:0] fill;
    logic [15:0] left_acc, right_acc;
    mode_t mode;
    logic [HOLD_BITS-1:0] hold_cnt;
    out_item_t drive_q[$];
    int unsigned errors, checked, ends;

    function new();
      diff_thr = DIFF_THR_RST;
      tape_thr = '0;
      spd_low = '0;
      spd_high = '0;
      spd_rot = '0;
      rot_hold = ROT_HOLD_RST;
      slot = '0;
      fill = '0;
      left_acc = '0;
      right_acc = '0;
      mode = MODE_FOLLOW;
      hold_cnt = '0;
      errors = 0;
      checked = 0;
      ends = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DIFF_THR:   diff_thr = data[SAMPLE_BITS-1:0];
        REG_TAPE_THR:   tape_thr = data[SAMPLE_BITS-1:0];
        REG_SPEED_LOW:  spd_low  = data[SPEED_BITS-1:0];
        REG_SPEED_HIGH: spd_high = data[SPEED_BITS-1:0];
        REG_SPEED_ROT:  spd_rot  = data[SPEED_BITS-1:0];
        REG_ROT_HOLD:   rot_hold = data[HOLD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // Works out the drive that one accepted item leads to.
    function void note_input(in_item_t it);
      out_item_t r;
      int unsigned lm, rm;
      r = '0;
      case (it.action)
        ACT_SAMPLE: begin
          if (fill == WIN_DEPTH) begin
            left_acc -= 16'(left_win[slot]);
            right_acc -= 16'(right_win[slot]);
          end else begin
            fill++;
          end
          left_win[slot] = it.left_sample;
          right_win[slot] = it.right_sample;
          left_acc += 16'(it.left_sample);
          right_acc += 16'(it.right_sample);
          slot++;
        end
        ACT_ROTATE: begin
          mode = MODE_ROTATE;
          hold_cnt = rot_hold;
        end
        ACT_RESUME: mode = MODE_FOLLOW;
        default: ;
      endcase
      lm = (fill == 0) ? 0 : int'(left_acc) / int'(fill);
      rm = (fill == 0) ? 0 : int'(right_acc) / int'(fill);
      if (mode == MODE_FOLLOW) begin
        if (rm > lm + diff_thr) begin
          r.left_speed = spd_low;
          r.right_speed = spd_high;
        end else if (lm > rm + diff_thr) begin
          r.left_speed = spd_high;
          r.right_speed = spd_low;
        end else begin
          r.left_speed = spd_high;
          r.right_speed = spd_high;
        end
      end else if (mode == MODE_ROTATE) begin
        if (it.action == ACT_SAMPLE && hold_cnt == 0 && rm > tape_thr && lm > tape_thr) begin
          mode = MODE_STOPPED;
          r.turn_done = 1'b1;
        end else begin
          // The hold only counts down on sample pairs.
          if (it.action == ACT_SAMPLE && hold_cnt != 0) hold_cnt--;
          r.left_speed = spd_rot;
          r.right_speed = spd_rot;
          r.left_reverse = 1'b1;
        end
      end
      r.mode_now = mode;
      r.left_average = lm[SAMPLE_BITS-1:0];
      r.right_average = rm[SAMPLE_BITS-1:0];
      drive_q.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (drive_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item waiting, actual %h", $time, got);
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (got.turn_done) ends++;
      cmp("left_speed", want.left_speed, got.left_speed);
      cmp("right_speed", want.right_speed, got.right_speed);
      cmp("left_reverse", want.left_reverse, got.left_reverse);
      cmp("right_reverse", want.right_reverse, got.right_reverse);
      cmp("turn_done", want.turn_done, got.turn_done);
      cmp("mode_now", want.mode_now, got.mode_now);
      cmp("left_average", want.left_average, got.left_average);
      cmp("right_average", want.right_average, got.right_average);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  steer_scoreboard sb;
  bit steady = 1'b0;
  bit hold_off = 1'b0;
  int unsigned items_sent = 0;
  logic [SAMPLE_BITS-1:0] left_base = 12'd2000;
  logic [SAMPLE_BITS-1:0] right_base = 12'd2000;

  two_sensor_tape_steering u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t mk(logic [1:0] act, logic [11:0] l, logic [11:0] r);
    in_item_t it;
    it.action = act;
    it.left_sample = l;
    it.right_sample = r;
    return it;
  endfunction

  // A reading scattered around the current surface level, now and then an extreme.
  function automatic logic [SAMPLE_BITS-1:0] near(logic [SAMPLE_BITS-1:0] base);
    int v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return '0;
    if (pick < 8) return '1;
    if (pick < 12) return SAMPLE_BITS'($urandom);
    v = int'(base) + $urandom_range(0, 400) - 200;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    // The robot moves onto a new surface: dark, bright, or anything.
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          left_base = SAMPLE_BITS'($urandom_range(0, 1000));
          right_base = SAMPLE_BITS'($urandom_range(0, 1000));
        end
        1: begin
          left_base = SAMPLE_BITS'($urandom_range(3000, 4095));
          right_base = SAMPLE_BITS'($urandom_range(3000, 4095));
        end
        default: begin
          left_base = SAMPLE_BITS'($urandom);
          right_base = SAMPLE_BITS'($urandom);
        end
      endcase
    end
    it = mk(ACT_SAMPLE, near(left_base), near(right_base));
    if (pick < 6) it.action = ACT_ROTATE;
    else if (pick < 9) it.action = ACT_RESUME;
    else if (pick < 11) it.action = ACT_UNUSED;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
  endtask

  // Stop offering and let the block finish everything before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Upper data bits of the narrow registers carry noise that must be dropped.
  task automatic apply_setting(input logic [11:0] diff, input logic [11:0] tape,
                               input logic [7:0] lo, input logic [7:0] hi,
                               input logic [7:0] rot, input logic [15:0] hold);
    put_reg(REG_DIFF_THR, {4'($urandom), diff});
    put_reg(REG_TAPE_THR, {4'($urandom), tape});
    put_reg(REG_SPEED_LOW, {8'($urandom), lo});
    put_reg(REG_SPEED_HIGH, {8'($urandom), hi});
    put_reg(REG_SPEED_ROT, {8'($urandom), rot});
    put_reg(REG_ROT_HOLD, hold);
    put_reg(REG_NONE_LO, 16'($urandom));
    put_reg(REG_NONE_HI, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Result side: takes items at random, or always while steady, with one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_off) begin
        hold_off = 1'b0;
        stall_left = 400;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  initial begin
    in_item_t seq[$];
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, with empty windows at first.
    seq = '{mk(ACT_UNUSED, 12'hFFF, 12'hFFF), mk(ACT_RESUME, '0, '0),
            mk(ACT_SAMPLE, 12'hAAA, 12'h555), mk(ACT_ROTATE, '0, '0)};
    foreach (seq[i]) send_item(seq[i]);
    settle();

    // Steering both ways, a short hold, an ending, and rotate from each mode.
    apply_setting(12'd100, 12'd2000, 8'd40, 8'd200, 8'd120, 16'd2);
    seq = '{mk(ACT_RESUME, '0, '0), mk(ACT_SAMPLE, 12'hFFF, 12'h000),
            mk(ACT_SAMPLE, 12'h000, 12'hFFF), mk(ACT_SAMPLE, 12'h000, 12'hFFF),
            mk(ACT_ROTATE, '0, '0), mk(ACT_SAMPLE, 12'hFFF, 12'hFFF),
            mk(ACT_SAMPLE, 12'hFFF, 12'hFFF), mk(ACT_UNUSED, '0, '0),
            mk(ACT_SAMPLE, 12'hFFF, 12'hFFF), mk(ACT_SAMPLE, 12'h000, 12'h000),
            mk(ACT_UNUSED, '0, '0), mk(ACT_ROTATE, '0, '0), mk(ACT_ROTATE, '0, '0),
            mk(ACT_SAMPLE, 12'h555, 12'hAAA), mk(ACT_RESUME, '0, '0)};
    foreach (seq[i]) send_item(seq[i]);
    settle();

    // A zero hold checks for tape on the very first sample pair.
    apply_setting(12'd0, 12'd0, 8'd255, 8'd0, 8'd255, 16'd0);
    seq = '{mk(ACT_ROTATE, '0, '0), mk(ACT_SAMPLE, 12'h000, 12'h000),
            mk(ACT_SAMPLE, 12'hFFF, 12'hFFF), mk(ACT_RESUME, '0, '0),
            mk(ACT_UNUSED, '0, '0)};
    foreach (seq[i]) send_item(seq[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        0: apply_setting(12'd0, 12'd0, 8'd0, 8'd255, 8'd255, 16'd0);
        1: apply_setting(12'd4095, 12'd4095, 8'd255, 8'd0, 8'd0, 16'd65535);
        default: apply_setting(12'($urandom_range(0, 1200)), 12'($urandom_range(300, 3800)),
                               8'($urandom), 8'($urandom), 8'($urandom),
                               16'($urandom_range(0, 10)));
      endcase
      steady = (ph == 3);
      if (ph == 4) hold_off = 1'b1;
      repeat (ITEMS_PER_PHASE) send_item(random_item());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d items over %0d register settings; %0d results checked.",
             items_sent, N_PHASES + 3, sb.checked);
    $display("Rotations ended on tape: %0d, mismatches: %0d.", sb.ends, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
